/* rtl/odo_pkg.sv */
// shared types, constants and tables for the wheel odometry block
// no dependencies; used by every other file of the block
`default_nettype none

package odo_pkg;

    // field widths
    localparam int unsigned CNT_IN_W   = 16;
    localparam int unsigned TIME_W     = 20;
    localparam int unsigned CFG_W      = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned THR_W      = 15;
    localparam int unsigned SPAN_W     = 16;
    localparam int unsigned OUT_W      = 32;

    // internal widths
    localparam int unsigned PROD_W     = 50;   // (dL +/- dR) * per-count factor
    localparam int unsigned VEC_W      = 44;   // cordic vector components
    localparam int unsigned ZW         = 34;   // cordic residual angle
    localparam int unsigned ACC_W      = 48;
    localparam int unsigned SPD_W      = 64;   // scaled speed numerators
    localparam int unsigned QUO_W      = 56;   // division shift register
    localparam int unsigned SEQ_W      = 6;    // sequencer step counter

    // cordic defaults and scale
    localparam int unsigned CORDIC_STEPS_DEF = 24;
    localparam logic [24:0] KINV_Q24   = 25'd10188014;

    // speed scale factors
    localparam logic [13:0] LIN_MUL    = 14'd15625;
    localparam logic [14:0] ANG_MUL    = 15'd24544;

    // register reset values
    localparam logic [31:0] MPC_RST    = 32'd407201;
    localparam logic [31:0] TPC_RST    = 32'd181028;
    localparam logic [14:0] THR_RST    = 15'd5000;
    localparam logic [15:0] SPAN_RST   = 16'd5600;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MPC  = 2'd0,
        CFG_TPC  = 2'd1,
        CFG_THR  = 2'd2,
        CFG_SPAN = 2'd3
    } t_cfg_idx;

    // sequencer commands to the datapath
    typedef struct packed {
        logic             load_in;
        logic             delta;
        logic             mul;
        logic             ldv;
        logic             scale;
        logic             iter;
        logic             acc;
        logic             muls;
        logic             dinit;
        logic             div;
        logic             dend;
        logic             done;
        logic             pass;
        logic [SEQ_W-1:0] cnt;
    } t_cmd;

    // datapath status back to the sequencer
    typedef struct packed {
        logic out_free;
    } t_status;

    // arctangent table, 2^32 = one full turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/odo_if.sv */
// valid/ready channel interfaces for encoder samples and odometry results
// depends on odo_pkg for field widths
`default_nettype none

interface odo_in_if;
    logic                              valid;
    logic                              ready;
    logic [odo_pkg::CNT_IN_W-1:0]      left_count;
    logic [odo_pkg::CNT_IN_W-1:0]      right_count;
    logic [odo_pkg::TIME_W-1:0]        elapsed_us;

    modport source (output valid, left_count, right_count, elapsed_us, input ready);
    modport sink   (input valid, left_count, right_count, elapsed_us, output ready);
endinterface

interface odo_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [odo_pkg::OUT_W-1:0]  pos_x;
    logic signed [odo_pkg::OUT_W-1:0]  pos_y;
    logic [odo_pkg::OUT_W-1:0]         heading_angle;
    logic signed [odo_pkg::OUT_W-1:0]  linear_speed;
    logic signed [odo_pkg::OUT_W-1:0]  angular_speed;
    logic                              standstill;

    modport source (output valid, pos_x, pos_y, heading_angle, linear_speed,
                    angular_speed, standstill, input ready);
    modport sink   (input valid, pos_x, pos_y, heading_angle, linear_speed,
                    angular_speed, standstill, output ready);
endinterface

`default_nettype wire

/* rtl/odo_ctrl.sv */
// sequencer for the odometry datapath: one sample at a time through all steps
// depends on odo_pkg for command and status types
`default_nettype none

module odo_ctrl #(
    parameter int unsigned CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  odo_pkg::t_status     i_status,
    output odo_pkg::t_cmd        o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DELTA = 12'b000000000010,
        S_MUL   = 12'b000000000100,
        S_LDV   = 12'b000000001000,
        S_SCALE = 12'b000000010000,
        S_ITER  = 12'b000000100000,
        S_ACC   = 12'b000001000000,
        S_MULS  = 12'b000010000000,
        S_DINIT = 12'b000100000000,
        S_DIV   = 12'b001000000000,
        S_DEND  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    localparam logic [odo_pkg::SEQ_W-1:0] ITER_LAST = odo_pkg::SEQ_W'(CORDIC_STEPS - 1);
    localparam logic [odo_pkg::SEQ_W-1:0] DIV_LAST  = odo_pkg::SEQ_W'(odo_pkg::QUO_W - 1);

    t_state                   r_state, n_state;
    logic                     r_pass, n_pass;
    logic [odo_pkg::SEQ_W-1:0] r_cnt, n_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DELTA;
                end
            end
            S_DELTA: n_state = S_MUL;
            S_MUL:   n_state = S_LDV;
            S_LDV: begin
                n_pass  = 1'b0;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_cnt   = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_LAST) begin
                    if (r_pass) begin
                        n_state = S_ACC;
                    end else begin
                        n_pass  = 1'b1;
                        n_state = S_SCALE;
                    end
                end
            end
            S_ACC:  n_state = S_MULS;
            S_MULS: begin
                n_pass  = 1'b0;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DEND;
                end
            end
            S_DEND: begin
                if (r_pass) begin
                    n_state = S_DONE;
                end else begin
                    n_pass  = 1'b1;
                    n_state = S_DINIT;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_cnt   <= n_cnt;
        end
    end

    // commands
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.load_in = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.delta   = (r_state == S_DELTA);
    assign o_cmd.mul     = (r_state == S_MUL);
    assign o_cmd.ldv     = (r_state == S_LDV);
    assign o_cmd.scale   = (r_state == S_SCALE);
    assign o_cmd.iter    = (r_state == S_ITER);
    assign o_cmd.acc     = (r_state == S_ACC);
    assign o_cmd.muls    = (r_state == S_MULS);
    assign o_cmd.dinit   = (r_state == S_DINIT);
    assign o_cmd.div     = (r_state == S_DIV);
    assign o_cmd.dend    = (r_state == S_DEND);
    assign o_cmd.done    = (r_state == S_DONE) && i_status.out_free;
    assign o_cmd.pass    = r_pass;
    assign o_cmd.cnt     = r_cnt;

endmodule

`default_nettype wire

/* rtl/odo_dp.sv */
// odometry datapath: deltas, products, shared cordic, shared divider, accumulators
// depends on odo_pkg; driven by odo_ctrl commands
`default_nettype none

module odo_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  odo_pkg::t_cmd                          i_cmd,
    output odo_pkg::t_status                       o_status,
    input  wire logic [odo_pkg::CNT_IN_W-1:0]      i_left_count,
    input  wire logic [odo_pkg::CNT_IN_W-1:0]      i_right_count,
    input  wire logic [odo_pkg::TIME_W-1:0]        i_elapsed_us,
    input  wire logic                              i_cfg_we,
    input  wire logic [odo_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [odo_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [odo_pkg::OUT_W-1:0]       o_pos_x,
    output logic signed [odo_pkg::OUT_W-1:0]       o_pos_y,
    output logic [odo_pkg::OUT_W-1:0]              o_heading_angle,
    output logic signed [odo_pkg::OUT_W-1:0]       o_linear_speed,
    output logic signed [odo_pkg::OUT_W-1:0]       o_angular_speed,
    output logic                                   o_standstill
);

    localparam int unsigned CW  = odo_pkg::CNT_IN_W;
    localparam int unsigned VW  = odo_pkg::VEC_W;
    localparam int unsigned ZW  = odo_pkg::ZW;
    localparam int unsigned PW  = odo_pkg::PROD_W;
    localparam int unsigned SW  = odo_pkg::SPD_W;
    localparam int unsigned QW  = odo_pkg::QUO_W;
    localparam int unsigned TW  = odo_pkg::TIME_W;
    localparam int unsigned AW  = odo_pkg::ACC_W;
    localparam int unsigned OW  = odo_pkg::OUT_W;

    // configuration registers
    logic [31:0]                   r_mpc, r_tpc;
    logic [odo_pkg::THR_W-1:0]     r_thr;
    logic [odo_pkg::SPAN_W-1:0]    r_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpc  <= odo_pkg::MPC_RST;
            r_tpc  <= odo_pkg::TPC_RST;
            r_thr  <= odo_pkg::THR_RST;
            r_span <= odo_pkg::SPAN_RST;
        end else if (i_cfg_we) begin
            case (odo_pkg::t_cfg_idx'(i_cfg_idx))
                odo_pkg::CFG_MPC:  r_mpc  <= i_cfg_data;
                odo_pkg::CFG_TPC:  r_tpc  <= i_cfg_data;
                odo_pkg::CFG_THR:  r_thr  <= i_cfg_data[odo_pkg::THR_W-1:0];
                odo_pkg::CFG_SPAN: r_span <= i_cfg_data[odo_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // rollover fold of one signed delta
    function automatic logic signed [CW-1:0] fold(input logic signed [CW-1:0] m,
                                                  input logic [odo_pkg::THR_W-1:0] thr,
                                                  input logic [odo_pkg::SPAN_W-1:0] span);
        logic signed [CW:0] m17;
        logic signed [CW:0] neg17;
        logic signed [CW:0] thr17;
        logic signed [CW-1:0] res;
        m17   = {m[CW-1], m};
        neg17 = -m17;
        thr17 = {2'b00, thr};
        res   = m;
        if (m[CW-1] && (neg17 > thr17)) begin
            res = m + span;
        end else if (m17 > thr17) begin
            res = m - span;
        end
        return res;
    endfunction

    // sample and state registers
    logic [CW-1:0]              r_left, r_right, r_prev_l, r_prev_r;
    logic [TW-1:0]              r_el;
    logic signed [CW-1:0]       r_dl, r_dr;
    logic signed [PW-1:0]       r_p, r_t;
    logic signed [VW-1:0]       r_x, r_y;
    logic signed [ZW-1:0]       r_z;
    logic [31:0]                r_ang;
    logic [AW-1:0]              r_acc_x, r_acc_y;
    logic [31:0]                r_head;
    logic signed [SW-1:0]       r_pl, r_pa;
    logic [QW-1:0]              r_num;
    logic [TW-1:0]              r_rem;
    logic                       r_neg;
    logic [OW-1:0]              r_lin, r_angs;
    logic                       r_out_valid;

    // delta path
    logic signed [CW-1:0] dr_raw, dl_raw;
    assign dr_raw = r_right - r_prev_r;
    assign dl_raw = r_prev_l - r_left;

    // step distance, rounded to q.24
    logic signed [PW:0]   p_rnd;
    logic signed [VW-1:0] d_vec;
    assign p_rnd = {r_p[PW-1], r_p} + (PW+1)'(256);
    assign d_vec = VW'(p_rnd >>> 9);

    // gain compensation and quadrant fold
    logic signed [VW+25:0] x_prod, y_prod;
    logic signed [VW-1:0]  x_sc, y_sc;
    logic [31:0]           ang_use, ang_rot;
    logic                  flip;
    logic                  z_top;
    assign ang_use = i_cmd.pass ? r_head : r_ang;
    assign x_prod  = r_x * $signed({1'b0, odo_pkg::KINV_Q24}) + (VW+26)'(1 << 23);
    assign y_prod  = r_y * $signed({1'b0, odo_pkg::KINV_Q24}) + (VW+26)'(1 << 23);
    assign x_sc    = VW'(x_prod >>> 24);
    assign y_sc    = VW'(y_prod >>> 24);
    assign ang_rot = ang_use + 32'h40000000;
    assign flip    = ang_rot[31];
    assign z_top   = ang_use[31] ^ flip;

    // one micro-rotation
    logic [4:0]           sh;
    logic signed [VW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign sh = i_cmd.cnt[4:0];
    assign dx = r_y >>> sh;
    assign dy = r_x >>> sh;
    assign at = $signed({2'b00, odo_pkg::atan_turn(sh)});

    // divider step
    logic [TW:0]    d_trial;
    logic           d_ge;
    logic [SW-1:0]  mag;
    logic signed [SW-1:0] num_src;
    assign num_src = i_cmd.pass ? r_pa : r_pl;
    assign mag     = num_src[SW-1] ? SW'(-num_src) : SW'(num_src);
    assign d_trial = {r_rem, r_num[QW-1]};
    assign d_ge    = d_trial >= {1'b0, r_el};

    // saturation of the quotient to signed 32 bits
    logic [OW-1:0] q_sat;
    always_comb begin
        if (r_neg) begin
            if (r_num > QW'(33'h080000000)) begin
                q_sat = 32'h80000000;
            end else begin
                q_sat = -r_num[OW-1:0];
            end
        end else begin
            if (r_num > QW'(32'h7FFFFFFF)) begin
                q_sat = 32'h7FFFFFFF;
            end else begin
                q_sat = r_num[OW-1:0];
            end
        end
    end

    // accumulators and sample history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_head   <= '0;
        end else begin
            if (i_cmd.delta) begin
                r_prev_l <= r_left;
                r_prev_r <= r_right;
            end
            if (i_cmd.acc) begin
                r_acc_x <= r_acc_x + {r_x[AW-9:0], 8'h00};
                r_acc_y <= r_acc_y + {r_y[AW-9:0], 8'h00};
                r_head  <= r_head + r_t[31:0];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_left  <= i_left_count;
            r_right <= i_right_count;
            r_el    <= (i_elapsed_us == '0) ? TW'(1) : i_elapsed_us;
        end
        if (i_cmd.delta) begin
            r_dr <= fold(dr_raw, r_thr, r_span);
            r_dl <= fold(dl_raw, r_thr, r_span);
        end
        if (i_cmd.mul) begin
            r_p <= PW'(($signed({r_dl[CW-1], r_dl}) + $signed({r_dr[CW-1], r_dr}))
                       * $signed({1'b0, r_mpc}));
            r_t <= PW'(($signed({r_dr[CW-1], r_dr}) - $signed({r_dl[CW-1], r_dl}))
                       * $signed({1'b0, r_tpc}));
        end
        if (i_cmd.ldv) begin
            r_x   <= d_vec;
            r_y   <= '0;
            r_ang <= r_t[31:0];
        end
        if (i_cmd.scale) begin
            r_x <= flip ? -x_sc : x_sc;
            r_y <= flip ? -y_sc : y_sc;
            r_z <= $signed({{3{z_top}}, ang_use[30:0]});
        end
        if (i_cmd.iter) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
        if (i_cmd.muls) begin
            r_pl <= SW'(r_p * $signed({1'b0, odo_pkg::LIN_MUL}));
            r_pa <= SW'(r_t * $signed({1'b0, odo_pkg::ANG_MUL}));
        end
        if (i_cmd.dinit) begin
            r_num <= i_cmd.pass ? mag[SW-1:8] : QW'(mag[SW-1:11]);
            r_rem <= '0;
            r_neg <= num_src[SW-1];
        end
        if (i_cmd.div) begin
            r_rem <= d_ge ? TW'(d_trial - {1'b0, r_el}) : d_trial[TW-1:0];
            r_num <= {r_num[QW-2:0], d_ge};
        end
        if (i_cmd.dend) begin
            if (i_cmd.pass) begin
                r_angs <= q_sat;
            end else begin
                r_lin <= q_sat;
            end
        end
    end

    // result register and output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            o_pos_x         <= r_acc_x[AW-1:16];
            o_pos_y         <= r_acc_y[AW-1:16];
            o_heading_angle <= r_head;
            o_linear_speed  <= r_lin;
            o_angular_speed <= r_angs;
            o_standstill    <= (r_lin == '0) && (r_angs == '0);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

/* rtl/diff_drive_odometry.sv */
// Differential-drive wheel odometry. One sample is taken at a time: the input
// is ready only while the sequencer idles. A sample passes through the one
// shared CORDIC stage (one micro-rotation a cycle, run twice) and the one
// shared radix-2 divider (56 quotient bits a division, run twice). A
// finished result waits in the output register, so the next sample is taken
// while it is still unread. The user must write registers only while no
// sample is in flight; the block itself does not enforce this.
// depends on odo_pkg, odo_if, odo_ctrl and odo_dp
`default_nettype none

module diff_drive_odometry #(
    parameter int unsigned CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    odo_in_if.sink                             i_in,
    odo_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [odo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [odo_pkg::CFG_W-1:0]     i_cfg_data
);

    odo_pkg::t_cmd    cmd;
    odo_pkg::t_status status;
    logic             in_ready;

    // sequencer
    odo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // datapath
    odo_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_left_count    (i_in.left_count),
        .i_right_count   (i_in.right_count),
        .i_elapsed_us    (i_in.elapsed_us),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_pos_x         (o_out.pos_x),
        .o_pos_y         (o_out.pos_y),
        .o_heading_angle (o_out.heading_angle),
        .o_linear_speed  (o_out.linear_speed),
        .o_angular_speed (o_out.angular_speed),
        .o_standstill    (o_out.standstill)
    );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// self-checking bench for diff_drive_odometry: random and directed encoder samples
// depends on odo_pkg, odo_if and the rtl of the odometry block
`default_nettype none

module testbench;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic [19:0] elapsed;
    } t_sample;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic [31:0] lin_spd;
        logic [31:0] ang_spd;
        logic        still;
    } t_pose;

    localparam int  N_ROT      = 24;
    localparam int  HOLD_LEN   = 800;
    localparam int  WDOG_LIMIT = 20000;
    localparam longint KINV    = longint'(odo_pkg::KINV_Q24);
    localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;

    // arctangent steps, one full turn = 2^32
    localparam logic [31:0] ATAN_STEP [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [odo_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [odo_pkg::CFG_W-1:0] i_cfg_data;

    odo_in_if  in_ch ();
    odo_out_if out_ch ();

    diff_drive_odometry u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor copy of registers and odometry state
    logic [31:0] mdl_mpc, mdl_tpc;
    logic [14:0] mdl_thr;
    logic [15:0] mdl_span;
    logic [15:0] mdl_prev_l, mdl_prev_r;
    logic [63:0] mdl_acc_x, mdl_acc_y;
    logic [31:0] mdl_heading;

    t_sample samples_pending[$];
    t_pose   poses_expected[$];
    int      err_count;
    int      send_idle, recv_stall;
    int      hold_req, hold_ack, hold_cnt;
    int      quiet_cycles;
    logic    in_taken;
    logic [15:0] gen_l, gen_r;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int fold_delta(int m);
        int thr;
        int span;
        thr  = int'(mdl_thr);
        span = int'(mdl_span);
        if (m < 0 && -m > thr)
            m = span + m;
        else if (m > 0 && m > thr)
            m = m - span;
        return int'(shortint'(m[15:0]));
    endfunction

    function automatic longint sat32(longint v);
        if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
        if (v < -longint'(32'sh7FFFFFFF) - 1) return -longint'(32'sh7FFFFFFF) - 1;
        return v;
    endfunction

    // gain-corrected cordic rotation by a binary angle
    task automatic cordic_rotate(inout longint x, inout longint y, input logic [31:0] ang);
        logic [31:0] z;
        logic [31:0] zq;
        longint r;
        longint dx;
        longint dy;
        x = (x * KINV + (longint'(1) <<< 23)) >>> 24;
        y = (y * KINV + (longint'(1) <<< 23)) >>> 24;
        z  = ang;
        zq = z + 32'h40000000;
        if (zq[31]) begin
            x = -x;
            y = -y;
            z = z + 32'h80000000;
        end
        r = longint'(signed'(z));
        for (int i = 0; i < N_ROT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
                x = x - dx; y = y + dy; r = r - longint'(ATAN_STEP[i]);
            end else begin
                x = x + dx; y = y - dy; r = r + longint'(ATAN_STEP[i]);
            end
        end
    endtask

    // advance the odometry state by one sample and give the expected pose
    task automatic advance_odometry(input t_sample s, output t_pose res);
        int dl;
        int dr;
        longint p;
        longint t;
        longint e;
        longint sx;
        longint sy;
        longint lin;
        longint ang;
        logic [31:0] tb;
        logic [15:0] raw_r;
        logic [15:0] raw_l;
        e = (s.elapsed == 0) ? 1 : longint'(s.elapsed);
        raw_r = s.right - mdl_prev_r;
        raw_l = mdl_prev_l - s.left;
        dr = fold_delta(int'(shortint'(raw_r)));
        dl = fold_delta(int'(shortint'(raw_l)));
        p  = longint'(dl + dr) * longint'({32'b0, mdl_mpc});
        t  = longint'(dr - dl) * longint'({32'b0, mdl_tpc});
        tb = t[31:0];
        sx = (p + 256) >>> 9;
        sy = 0;
        cordic_rotate(sx, sy, tb);
        cordic_rotate(sx, sy, mdl_heading);
        mdl_acc_x   = (mdl_acc_x + (sx <<< 8)) & MASK48;
        mdl_acc_y   = (mdl_acc_y + (sy <<< 8)) & MASK48;
        mdl_heading = mdl_heading + tb;
        mdl_prev_l  = s.left;
        mdl_prev_r  = s.right;
        lin = sat32((p * 15625) / (2048 * e));
        ang = sat32((t * 24544) / (256 * e));
        res.pos_x   = mdl_acc_x[47:16];
        res.pos_y   = mdl_acc_y[47:16];
        res.heading = mdl_heading;
        res.lin_spd = lin[31:0];
        res.ang_spd = ang[31:0];
        res.still   = (lin == 0 && ang == 0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    // accepted samples feed the predictor, accepted results are checked
    always @(posedge i_clk) begin : monitor
        t_pose want;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                advance_odometry(t_sample'{in_ch.left_count, in_ch.right_count,
                                           in_ch.elapsed_us}, want);
                poses_expected.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (poses_expected.size() == 0) begin
                    report_mismatch("result transfer with nothing expected",
                                    out_ch.pos_x, '0);
                end else begin
                    want = poses_expected.pop_front();
                    if (out_ch.pos_x !== want.pos_x)
                        report_mismatch("pos_x", out_ch.pos_x, want.pos_x);
                    if (out_ch.pos_y !== want.pos_y)
                        report_mismatch("pos_y", out_ch.pos_y, want.pos_y);
                    if (out_ch.heading_angle !== want.heading)
                        report_mismatch("heading_angle", out_ch.heading_angle, want.heading);
                    if (out_ch.linear_speed !== want.lin_spd)
                        report_mismatch("linear_speed", out_ch.linear_speed, want.lin_spd);
                    if (out_ch.angular_speed !== want.ang_spd)
                        report_mismatch("angular_speed", out_ch.angular_speed, want.ang_spd);
                    if (out_ch.standstill !== want.still)
                        report_mismatch("standstill", {31'b0, out_ch.standstill},
                                        {31'b0, want.still});
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", poses_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // sample driver
    always @(negedge i_clk) begin : driver
        t_sample s;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (samples_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                s = samples_pending.pop_front();
                in_ch.left_count  <= s.left;
                in_ch.right_count <= s.right;
                in_ch.elapsed_us  <= s.elapsed;
                in_ch.valid       <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            hold_cnt     <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt     <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic add_sample(input logic [15:0] l, input logic [15:0] r,
                              input logic [19:0] e);
        samples_pending.push_back(t_sample'{l, r, e});
        gen_l = l;
        gen_r = r;
    endtask

    // mostly plausible wheel motion, with rollovers and raw noise mixed in
    task automatic add_random(input int n);
        int kind;
        int lim;
        int dl;
        int dr;
        logic [19:0] e;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(99);
            lim  = (mdl_thr > 0) ? int'(mdl_thr) : 1;
            if (kind < 65) begin
                dl = $urandom_range(2 * lim) - lim;
                dr = (kind < 10) ? dl : $urandom_range(2 * lim) - lim;
            end else if (kind < 85) begin
                dl = $urandom_range(1) ? lim + $urandom_range(40) : -lim - $urandom_range(40);
                dr = $urandom_range(1) ? lim + $urandom_range(40) - 20
                                       : $urandom_range(60000) - 30000;
            end else begin
                dl = $urandom_range(65535);
                dr = $urandom_range(65535);
            end
            case ($urandom_range(4))
                0:       e = 20'($urandom_range(3));
                1:       e = 20'($urandom_range(20'hFFFFF));
                default: e = 20'($urandom_range(100000, 20000));
            endcase
            add_sample(gen_l + 16'(dl), gen_r + 16'(dr), e);
        end
    endtask

    task automatic write_reg(input odo_pkg::t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            odo_pkg::CFG_MPC:  mdl_mpc  = val;
            odo_pkg::CFG_TPC:  mdl_tpc  = val;
            odo_pkg::CFG_THR:  mdl_thr  = val[14:0];
            odo_pkg::CFG_SPAN: mdl_span = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] mpc, input logic [31:0] tpc,
                            input logic [31:0] thr, input logic [31:0] span);
        write_reg(odo_pkg::CFG_MPC, mpc);
        write_reg(odo_pkg::CFG_TPC, tpc);
        write_reg(odo_pkg::CFG_THR, thr);
        write_reg(odo_pkg::CFG_SPAN, span);
    endtask

    // run queued samples to completion with the given idling
    task automatic run_phase(input int s_idle, input int r_stall);
        send_idle  = s_idle;
        recv_stall = r_stall;
        wait (samples_pending.size() == 0 && !in_ch.valid && poses_expected.size() == 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = odo_pkg::CFG_MPC;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.left_count = '0;
        in_ch.right_count = '0;
        in_ch.elapsed_us = '0;
        out_ch.ready     = 1'b0;
        in_taken         = 1'b0;
        hold_req = 0; hold_ack = 0; hold_cnt = 0;
        quiet_cycles = 0;
        err_count = 0;
        send_idle = 0; recv_stall = 0;
        gen_l = '0; gen_r = '0;
        mdl_mpc = odo_pkg::MPC_RST; mdl_tpc = odo_pkg::TPC_RST;
        mdl_thr = odo_pkg::THR_RST; mdl_span = odo_pkg::SPAN_RST;
        mdl_prev_l = '0; mdl_prev_r = '0;
        mdl_acc_x = '0; mdl_acc_y = '0; mdl_heading = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, zero time, fold edges, spin on the spot
        add_sample(16'h0000, 16'h0000, 20'd0);
        add_sample(16'h0000, 16'h0000, 20'd1);
        add_sample(16'hFF9C, 16'h0064, 20'd50000);
        add_sample(16'hFF9C, 16'h0064, 20'hFFFFF);
        add_sample(16'hEC78 - 16'd1, 16'h1388 + 16'h0064, 20'd0);
        add_sample(16'hEC77 - 16'd5001, 16'h13EC + 16'd5001, 20'd1);
        add_sample(gen_l + 16'd5000, gen_r - 16'd5000, 20'd1);
        add_sample(gen_l + 16'd5001, gen_r - 16'd5001, 20'd7);
        add_sample(gen_l - 16'd200, gen_r - 16'd200, 20'd40000);
        add_sample(16'hFFFF, 16'hFFFF, 20'd3);
        add_sample(16'h8000, 16'h7FFF, 20'd1);
        add_sample(16'h7FFF, 16'h8000, 20'hFFFFF);
        add_sample(16'h5555, 16'hAAAA, 20'h55555);
        add_sample(16'hAAAA, 16'h5555, 20'hAAAAA);
        add_sample(16'hAAAA, 16'h5555, 20'd10);
        run_phase(0, 0);

        // largest scale factors and fold threshold: speeds saturate, position wraps
        set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFF, 32'hFFFF);
        add_sample(gen_l - 16'h7FFF, gen_r + 16'h7FFF, 20'd1);
        add_sample(gen_l + 16'h7FFF, gen_r - 16'h7FFF, 20'd1);
        add_sample(gen_l + 16'h8000, gen_r + 16'h8000, 20'd0);
        add_random(300);
        run_phase(53, 0);

        // zero registers, long receiver hold-off to fill the block
        set_regs(32'h0, 32'h0, 32'h0, 32'h0);
        add_random(100);
        hold_req = hold_req + 1;
        run_phase(0, 53);

        // random registers, both sides idling
        set_regs($urandom, $urandom, $urandom_range(32767), $urandom_range(65535));
        add_random(400);
        run_phase(29, 29);

        set_regs($urandom_range(2000000), $urandom_range(1000000),
                 $urandom_range(6000, 100), $urandom_range(65535));
        add_random(300);
        hold_req = hold_req + 1;
        run_phase(0, 53);

        // back to the reset values
        set_regs(odo_pkg::MPC_RST, odo_pkg::TPC_RST, 32'(odo_pkg::THR_RST),
                 32'(odo_pkg::SPAN_RST));
        add_random(400);
        run_phase(53, 0);
        add_random(500);
        run_phase(0, 0);

        repeat (200) @(negedge i_clk);
        if (err_count == 0 && poses_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

/* diff_drive_odometry.f */
rtl/odo_pkg.sv
rtl/odo_if.sv
rtl/odo_ctrl.sv
rtl/odo_dp.sv
rtl/diff_drive_odometry.sv
sim/testbench.sv
